@@ design/fatan_pkg.sv @@
// ----------------------------------------------------------------------------
// fatan_pkg: shared types, constants and helpers for the atan2 pipeline
// Fixed widths of the ratio and polynomial path, Horner coefficients in Q2.30,
// control word passed along the cell chains, rounding and pi helpers.
// ----------------------------------------------------------------------------
package fatan_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_FRAC_DEF  = 13;

	localparam int ANGLE_W = 16;   // result port width
	localparam int QUOT_W  = 17;   // ratio quotient bits, Q1.16 before rounding
	localparam int Z_W     = 17;   // signed ratio, Q1.15
	localparam int Z2_W    = 31;   // z^2, unsigned Q1.30
	localparam int ACC_W   = 32;   // Horner accumulator, signed Q2.30
	localparam int PROD_W  = 64;   // product / rounding width
	localparam int Q30_SHIFT = 30;
	localparam int POLY_SHIFT_BASE = 45;
	localparam int HORNER_STEPS = 4;

	localparam logic [63:0] PI_Q32 = 64'd13493037705;

	// c9, -c7, c5, -c3, c1 in Q2.30
	localparam logic signed [ACC_W-1:0] HORNER_COEF [0:HORNER_STEPS] = '{
		32'sd22371518,
		-32'sd91410863,
		32'sd193424926,
		-32'sd354656388,
		32'sd1073597943
	};

	typedef struct packed {
		logic valid;
		logic zero;   // both coordinates zero
		logic swap;   // |y| > |x|, ratio is x/y
		logic neg;    // signs of x and y differ
		logic xneg;
		logic yneg;
	} ctl_t;

	// round to nearest, halves away from zero, s >= 1
	function automatic logic signed [PROD_W-1:0] rnd_shift(
		input logic signed [PROD_W-1:0] v,
		input int unsigned s
	);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [63:0] pi_scaled(input int unsigned afb);
		return (PI_Q32 + (64'd1 << (31 - afb))) >> (32 - afb);
	endfunction

	function automatic logic [63:0] half_pi_scaled(input int unsigned afb);
		return (PI_Q32 + (64'd1 << (32 - afb))) >> (33 - afb);
	endfunction

endpackage

@@ design/fatan_div_cell.sv @@
// ----------------------------------------------------------------------------
// fatan_div_cell: one restoring-division cell
// Compares the partial remainder with the divisor, emits one quotient bit and
// hands the doubled remainder and the word's control to the next cell.
// ----------------------------------------------------------------------------
module fatan_div_cell #(
	parameter int W = fatan_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fatan_pkg::ctl_t            ctl_i,
	input  logic [W:0]                 rem_i,
	input  logic [W-1:0]               den_i,
	input  logic [fatan_pkg::QUOT_W-1:0] q_i,
	output fatan_pkg::ctl_t            ctl_o,
	output logic [W:0]                 rem_o,
	output logic [W-1:0]               den_o,
	output logic [fatan_pkg::QUOT_W-1:0] q_o
);
	import fatan_pkg::*;

	logic         ge;
	logic [W:0]   diff;

	assign ge   = rem_i >= {1'b0, den_i};
	assign diff = ge ? rem_i - {1'b0, den_i} : rem_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	// remainder stays below the divisor, so the doubled value fits W+1 bits
	always_ff @(posedge clk) begin
		rem_o <= {diff[W-1:0], 1'b0};
		den_o <= den_i;
		q_o   <= {q_i[QUOT_W-2:0], ge};
	end

endmodule

@@ design/fatan_horner_cell.sv @@
// ----------------------------------------------------------------------------
// fatan_horner_cell: one Horner step of the arctangent polynomial
// Multiplies the accumulator by z^2, then rounds back to Q2.30 and adds the
// next coefficient. Two register stages; z and z^2 travel alongside.
// ----------------------------------------------------------------------------
module fatan_horner_cell #(
	parameter logic signed [fatan_pkg::ACC_W-1:0] COEF = fatan_pkg::HORNER_COEF[1]
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fatan_pkg::ctl_t                   ctl_i,
	input  logic signed [fatan_pkg::ACC_W-1:0] acc_i,
	input  logic signed [fatan_pkg::Z_W-1:0]   z_i,
	input  logic [fatan_pkg::Z2_W-1:0]         z2_i,
	output fatan_pkg::ctl_t                   ctl_o,
	output logic signed [fatan_pkg::ACC_W-1:0] acc_o,
	output logic signed [fatan_pkg::Z_W-1:0]   z_o,
	output logic [fatan_pkg::Z2_W-1:0]         z2_o
);
	import fatan_pkg::*;

	ctl_t                       ctl_s1;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [Z_W-1:0]      z_s1;
	logic [Z2_W-1:0]            z2_s1;
	logic signed [PROD_W-1:0]   rnd;

	// full-width signed product, both operands extend to PROD_W
	assign prod = acc_i * $signed({1'b0, z2_i});
	assign rnd  = rnd_shift(prod_s1, Q30_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_o  <= '0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_o  <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		z_s1    <= z_i;
		z2_s1   <= z2_i;
		acc_o   <= ACC_W'(rnd) + COEF;
		z_o     <= z_s1;
		z2_o    <= z2_s1;
	end

endmodule

@@ design/fast_atan2_polynomial.sv @@
// ----------------------------------------------------------------------------
// fast_atan2_polynomial: pipelined fixed-point atan2(y, x)
// Ratio of the smaller to the larger magnitude by a row of division cells,
// odd degree-9 arctangent polynomial by a row of Horner cells, octant fixup.
// ----------------------------------------------------------------------------
//  channel   | strobe        | payload
//  ----------+---------------+--------------------------------------
//  command   | start / busy  | coord_y, coord_x  (COORD_WIDTH, signed)
//  result    | done          | angle             (16 bits, signed)
//
//  Stages in order: a prepare register, 17 division cells, ratio rounding,
//  squaring, 4 Horner cells of 2 stages each, final multiply, rounding
//  and octant correction. One word is taken every cycle; busy stays low.
//  Reset clears only the control words and done, not the data registers.
//  The receiver cannot stall; done is high for one cycle per word.
// ----------------------------------------------------------------------------
module fast_atan2_polynomial #(
	parameter int COORD_WIDTH     = fatan_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = fatan_pkg::ANGLE_FRAC_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_WIDTH-1:0]         coord_y,
	input  logic signed [COORD_WIDTH-1:0]         coord_x,
	output logic                                  done,
	output logic signed [fatan_pkg::ANGLE_W-1:0]  angle
);
	import fatan_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int RW  = ANGLE_FRAC_BITS + 4;
	localparam int EW  = (RW > ANGLE_W) ? RW : ANGLE_W;
	localparam int LAT = 1 + QUOT_W + 2 + 2 * HORNER_STEPS + 3;
	localparam logic signed [RW-1:0] PI_R = RW'(pi_scaled(ANGLE_FRAC_BITS));
	localparam logic signed [RW-1:0] HP_R = RW'(half_pi_scaled(ANGLE_FRAC_BITS));

	// prepare: magnitudes, order, signs
	logic [W-1:0] ay, ax;
	ctl_t         ctl_in;

	assign ay = coord_y[W-1] ? W'(-coord_y) : W'(coord_y);
	assign ax = coord_x[W-1] ? W'(-coord_x) : W'(coord_x);

	always_comb begin
		ctl_in       = '0;
		ctl_in.valid = start;
		ctl_in.zero  = (coord_y == '0) && (coord_x == '0);
		ctl_in.swap  = ay > ax;
		ctl_in.neg   = coord_y[W-1] ^ coord_x[W-1];
		ctl_in.xneg  = coord_x[W-1];
		ctl_in.yneg  = coord_y[W-1];
	end

	assign busy = 1'b0;

	ctl_t          ctl_d [0:QUOT_W];
	logic [W:0]    rem_d [0:QUOT_W];
	logic [W-1:0]  den_d [0:QUOT_W];
	logic [QUOT_W-1:0] q_d [0:QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_d[0] <= '0;
		end else begin
			ctl_d[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_d[0] <= {1'b0, (ay > ax) ? ax : ay};
		den_d[0] <= (ay > ax) ? ay : ax;
		q_d[0]   <= '0;
	end

	genvar k;
	generate
		for (k = 0; k < QUOT_W; k++) begin : g_div
			fatan_div_cell #(.W(W)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl_i (ctl_d[k]),
				.rem_i (rem_d[k]),
				.den_i (den_d[k]),
				.q_i   (q_d[k]),
				.ctl_o (ctl_d[k+1]),
				.rem_o (rem_d[k+1]),
				.den_o (den_d[k+1]),
				.q_o   (q_d[k+1])
			);
		end
	endgenerate

	// round the Q1.16 quotient to Q1.15 and apply the sign
	logic [Z_W-1:0]         zmag;
	ctl_t                   ctl_z_s1, ctl_z_s2;
	logic signed [Z_W-1:0]  z_s1, z_s2;
	logic signed [2*Z_W-1:0] z_sq;
	logic [Z2_W-1:0]        z2_s2;

	assign zmag = Z_W'(({1'b0, q_d[QUOT_W]} + (QUOT_W+1)'(1)) >> 1);
	assign z_sq = z_s1 * z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_z_s1 <= '0;
			ctl_z_s2 <= '0;
		end else begin
			ctl_z_s1 <= ctl_d[QUOT_W];
			ctl_z_s2 <= ctl_z_s1;
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= ctl_d[QUOT_W].neg ? $signed(-zmag) : $signed(zmag);
		z2_s2 <= z_sq[Z2_W-1:0];
		z_s2  <= z_s1;
	end

	ctl_t                   ctl_h [0:HORNER_STEPS];
	logic signed [ACC_W-1:0] acc_h [0:HORNER_STEPS];
	logic signed [Z_W-1:0]  z_h   [0:HORNER_STEPS];
	logic [Z2_W-1:0]        z2_h  [0:HORNER_STEPS];

	assign ctl_h[0] = ctl_z_s2;
	assign acc_h[0] = HORNER_COEF[0];
	assign z_h[0]   = z_s2;
	assign z2_h[0]  = z2_s2;

	generate
		for (k = 0; k < HORNER_STEPS; k++) begin : g_horner
			fatan_horner_cell #(.COEF(HORNER_COEF[k+1])) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl_i (ctl_h[k]),
				.acc_i (acc_h[k]),
				.z_i   (z_h[k]),
				.z2_i  (z2_h[k]),
				.ctl_o (ctl_h[k+1]),
				.acc_o (acc_h[k+1]),
				.z_o   (z_h[k+1]),
				.z2_o  (z2_h[k+1])
			);
		end
	endgenerate

	// final multiply by z, round to the angle scale, octant fixup
	ctl_t                     ctl_f_s1, ctl_f_s2;
	logic signed [ACC_W+Z_W-1:0] prod_f_s1;
	logic signed [RW-1:0]     p_s2;
	logic signed [PROD_W-1:0] p_rnd;
	logic signed [RW-1:0]     hp_sgn, base, offs, sum, res;
	logic signed [EW-1:0]     res_ext;

	assign p_rnd = rnd_shift(PROD_W'(prod_f_s1), POLY_SHIFT_BASE - ANGLE_FRAC_BITS);

	always_comb begin
		hp_sgn = ctl_f_s2.neg ? -HP_R : HP_R;
		base   = ctl_f_s2.swap ? hp_sgn - p_s2 : p_s2;
		offs   = ctl_f_s2.xneg ? (ctl_f_s2.yneg ? -PI_R : PI_R) : '0;
		sum    = base + offs;
		if (ctl_f_s2.zero) begin
			res = '0;
		end else if (sum > PI_R) begin
			res = PI_R;
		end else if (sum < -PI_R) begin
			res = -PI_R;
		end else begin
			res = sum;
		end
	end

	assign res_ext = EW'(res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_f_s1 <= '0;
			ctl_f_s2 <= '0;
			done     <= 1'b0;
		end else begin
			ctl_f_s1 <= ctl_h[HORNER_STEPS];
			ctl_f_s2 <= ctl_f_s1;
			done     <= ctl_f_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_f_s1 <= acc_h[HORNER_STEPS] * z_h[HORNER_STEPS];
		p_s2      <= RW'(p_rnd);
		angle     <= res_ext[ANGLE_W-1:0];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing after command");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a command");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start, LAT) && $past(coord_x, LAT) == '0 && $past(coord_y, LAT) == '0
		|-> angle == '0)
		else $error("zero vector gave a nonzero angle");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fast_atan2_polynomial
// Feeds (y, x) words through the command channel with random gaps, predicts
// each angle with a bit-exact fixed-point atan2 and checks every done word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int CW          = fatan_pkg::COORD_WIDTH_DEF;
	localparam int AFB         = fatan_pkg::ANGLE_FRAC_DEF;
	localparam int AW          = fatan_pkg::ANGLE_W;
	localparam int LATENCY     = 31;
	localparam int IDLE_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 530;

	// atan series coefficients in Q2.30
	localparam longint K9 = 64'sd22371518;
	localparam longint K7 = 64'sd91410863;
	localparam longint K5 = 64'sd193424926;
	localparam longint K3 = 64'sd354656388;
	localparam longint K1 = 64'sd1073597943;
	localparam longint unsigned PI_FX32 = 64'd13493037705;

	typedef struct {
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
		int                   gap;
	} vec_word_t;

	typedef struct {
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
		logic signed [AW-1:0] angle;
	} angle_exp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [CW-1:0] coord_y;
	logic signed [CW-1:0] coord_x;
	logic                 done;
	logic signed [AW-1:0] angle;

	vec_word_t  pending_words[$];
	angle_exp_t expected_angles[$];
	angle_exp_t got_exp;
	logic       word_taken;
	int         idle_cycles;
	int         error_count = 0;

	fast_atan2_polynomial dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.coord_y (coord_y),
		.coord_x (coord_x),
		.done    (done),
		.angle   (angle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round to nearest, halves away from zero
	function automatic longint shift_round(input longint v, input int s);
		longint unsigned mag;
		longint unsigned r;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint atan_series(input longint z);
		longint z2;
		longint acc;
		z2  = z * z;
		acc = K9;
		acc = shift_round(acc * z2, 30) - K7;
		acc = shift_round(acc * z2, 30) + K5;
		acc = shift_round(acc * z2, 30) - K3;
		acc = shift_round(acc * z2, 30) + K1;
		return shift_round(acc * z, 45 - AFB);
	endfunction

	function automatic logic signed [AW-1:0] predict_angle(
		input logic signed [CW-1:0] yin,
		input logic signed [CW-1:0] xin
	);
		longint pi_fx;
		longint hp_fx;
		longint y;
		longint x;
		longint ay;
		longint ax;
		longint num;
		longint den;
		longint z;
		longint res;
		bit     opp;
		pi_fx = longint'((PI_FX32 + (64'd1 << (31 - AFB))) >> (32 - AFB));
		hp_fx = longint'((PI_FX32 + (64'd1 << (32 - AFB))) >> (33 - AFB));
		y = longint'(yin);
		x = longint'(xin);
		if (x == 0 && y == 0)
			res = 0;
		else if (x == 0)
			res = (y > 0) ? hp_fx : -hp_fx;
		else if (y == 0)
			res = (x > 0) ? 0 : pi_fx;
		else begin
			ay  = (y < 0) ? -y : y;
			ax  = (x < 0) ? -x : x;
			opp = (y < 0) != (x < 0);
			num = (ay > ax) ? ax : ay;
			den = (ay > ax) ? ay : ax;
			z = longint'((longint'(num) * 32768 + den / 2) / den);
			if (opp)
				z = -z;
			if (ay > ax)
				res = (opp ? -hp_fx : hp_fx) - atan_series(z);
			else
				res = atan_series(z);
			if (x < 0)
				res = res + ((y < 0) ? -pi_fx : pi_fx);
			if (res > pi_fx)
				res = pi_fx;
			if (res < -pi_fx)
				res = -pi_fx;
		end
		return AW'(res);
	endfunction

	task automatic queue_word(input int y, input int x, input int gap);
		vec_word_t w;
		w.y   = CW'(y);
		w.x   = CW'(x);
		w.gap = gap;
		pending_words.push_back(w);
	endtask

	function automatic int draw_gap(input int style);
		case (style)
			0: return 0;
			1: return $urandom_range(0, 12);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
		endcase
	endfunction

	// driver: present the next word once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start   <= 1'b0;
			coord_y <= '0;
			coord_x <= '0;
		end else if (!start || word_taken) begin
			if (pending_words.size() == 0) begin
				start <= 1'b0;
			end else if (pending_words[0].gap > 0) begin
				pending_words[0].gap = pending_words[0].gap - 1;
				start   <= 1'b0;
				coord_y <= CW'($urandom);
				coord_x <= CW'($urandom);
			end else begin
				coord_y <= pending_words[0].y;
				coord_x <= pending_words[0].x;
				start   <= 1'b1;
				void'(pending_words.pop_front());
			end
		end
	end

	// monitor: log accepted words, check done words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_taken  <= 1'b0;
			idle_cycles <= 0;
		end else begin
			word_taken <= start && !busy;
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (start && !busy) begin
				got_exp.y     = coord_y;
				got_exp.x     = coord_x;
				got_exp.angle = predict_angle(coord_y, coord_x);
				expected_angles.push_back(got_exp);
			end
			if (done) begin
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected done word, angle %0d", $time, angle);
					error_count = error_count + 1;
				end else begin
					got_exp = expected_angles.pop_front();
					if (angle !== got_exp.angle) begin
						$display("%0t: angle for y=%0d x=%0d: expected %0d, actual %0d",
							$time, got_exp.y, got_exp.x, got_exp.angle, angle);
						error_count = error_count + 1;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("fast_atan2_polynomial: mismatch");
		$finish;
	end

	initial begin
		int style;
		int kind;
		int m;
		int y;
		int x;
		arst_n  = 1'b0;

		// axes, corners, diagonals and octant edges
		queue_word(0, 0, 0);
		queue_word(0, 5, 1);
		queue_word(0, -5, 0);
		queue_word(5, 0, 2);
		queue_word(-5, 0, 0);
		queue_word(32767, 0, 0);
		queue_word(-32768, 0, 3);
		queue_word(0, 32767, 0);
		queue_word(0, -32768, 0);
		queue_word(32767, 32767, 1);
		queue_word(-32768, -32768, 0);
		queue_word(-32768, 32767, 0);
		queue_word(32767, -32768, 2);
		queue_word(100, -100, 0);
		queue_word(-100, 100, 0);
		queue_word(1, 32767, 0);
		queue_word(1, -32768, 1);
		queue_word(-1, -32768, 0);
		queue_word(32767, 1, 0);
		queue_word(-32767, 1, 3);
		queue_word(32767, -1, 0);
		queue_word(-32768, -1, 0);
		queue_word(-1, -1, 0);
		queue_word(3, -2, 0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 40 == 0)
				style = $urandom_range(0, 2);
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					y = $urandom_range(0, 16) - 8;
					x = $urandom_range(0, 16) - 8;
				end
				1: begin
					// near an axis
					y = $urandom_range(0, 6) - 3;
					x = $signed(CW'($urandom));
					if ($urandom_range(0, 1)) begin
						m = y;
						y = x;
						x = m;
					end
				end
				2: begin
					// equal or nearly equal magnitudes
					m = $urandom_range(1, 32767);
					y = $urandom_range(0, 1) ? m : -m;
					x = ($urandom_range(0, 1) ? m : -m) + $urandom_range(0, 2) - 1;
					if (x > 32767)
						x = 32767;
				end
				default: begin
					y = $signed(CW'($urandom));
					x = $signed(CW'($urandom));
				end
			endcase
			queue_word(y, x, draw_gap(style));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || !(word_taken || !start))
			@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (error_count == 0)
			$display("fast_atan2_polynomial: match");
		else
			$display("fast_atan2_polynomial: mismatch");
		$finish;
	end

endmodule
